/* hw/rtl/fnpf_pkg.sv */
// ============================================================================
// fnpf_pkg
// Shared types, register codes and reset values of the nearest point filter.
// ============================================================================
package fnpf_pkg;

  localparam int CFG_INDEX_W       = 8;
  localparam int QUEUE_DEPTH_DEF   = 8;

  typedef logic signed [15:0] coord_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ROW_X         = 8'd0,
    REG_ROW_Y         = 8'd1,
    REG_ROW_Z         = 8'd2,
    REG_HALF_WIDTH    = 8'd3,
    REG_MAX_DEPTH     = 8'd4,
    REG_HEIGHT_WINDOW = 8'd5,
    REG_FILTER        = 8'd6,
    REG_DECIMATION    = 8'd7
  } cfg_reg_t;

  localparam logic [63:0] ROW_X_RST         = 64'h4000_0000_0000_0000;
  localparam logic [63:0] ROW_Y_RST         = 64'h0000_4000_0000_0000;
  localparam logic [63:0] ROW_Z_RST         = 64'h0000_0000_4000_0000;
  localparam logic [14:0] HALF_WIDTH_RST    = 15'd350;
  localparam logic [14:0] MAX_DEPTH_RST     = 15'd4000;
  localparam logic [31:0] HEIGHT_WINDOW_RST = 32'd111411205;
  localparam logic [31:0] FILTER_RST        = 32'd6554;
  localparam logic [7:0]  DECIMATION_RST    = 8'd1;

  typedef struct packed {
    logic [63:0] row_x;
    logic [63:0] row_y;
    logic [63:0] row_z;
    logic [14:0] half_width_mm;
    logic [14:0] max_depth_mm;
    logic [31:0] height_window;
    logic [31:0] filter_settings;
    logic [7:0]  decimation;
  } cfg_t;

  // classified point handed from front to back
  typedef struct packed {
    coord_t xt;
    coord_t yt;
    coord_t zt;
    logic   pass;
    logic   last;
  } q_item_t;

endpackage

/* hw/rtl/fnpf_point_if.sv */
// ============================================================================
// fnpf_point_if
// Input channel: one sensor point per word.
// ============================================================================
interface fnpf_point_if import fnpf_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t point_x;
  coord_t point_y;
  coord_t point_z;
  logic   point_valid;
  logic   last_point;

  modport source (output valid, point_x, point_y, point_z, point_valid, last_point,
                  input ready);
  modport sink   (input valid, point_x, point_y, point_z, point_valid, last_point,
                  output ready);
endinterface

/* hw/rtl/fnpf_result_if.sv */
// ============================================================================
// fnpf_result_if
// Result channel: nearest point and filtered distance, one word per cloud.
// ============================================================================
interface fnpf_result_if import fnpf_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t filtered_distance;
  coord_t nearest_x;
  coord_t nearest_y;
  coord_t nearest_z;
  logic   point_found;

  modport source (output valid, filtered_distance, nearest_x, nearest_y, nearest_z,
                  point_found, input ready);
  modport sink   (input valid, filtered_distance, nearest_x, nearest_y, nearest_z,
                  point_found, output ready);
endinterface

/* hw/rtl/fnpf_cfg_if.sv */
// ============================================================================
// fnpf_cfg_if
// Register write channel: index and data per word.
// ============================================================================
interface fnpf_cfg_if import fnpf_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [63:0]            data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/fnpf_front.sv */
// ============================================================================
// fnpf_front
// Decimation, frame transform and box test; pushes passing and last points.
// ============================================================================
module fnpf_front import fnpf_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  fnpf_point_if.sink    points,
  input  logic [CW-1:0] q_count,
  output logic          push,
  output q_item_t       push_item
);

  function automatic coord_t sat16(input logic signed [19:0] v);
    if (v > 20'sd32767) begin
      return 16'sh7fff;
    end else if (v < -20'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  logic               accept;
  logic               keep;
  logic [7:0]         dec_cnt;
  logic [7:0]         dec_eff;
  logic [8:0]         cnt_inc;
  logic [63:0]        rows [3];
  coord_t             pt [3];

  logic               s1_v, s1_kv, s1_last;
  logic signed [31:0] prod [3][3];

  logic signed [33:0] acc [3];
  coord_t             coord [3];

  logic               s2_v, s2_kv, s2_last;
  coord_t             s2_c [3];

  logic signed [16:0] y17, ay, x17, hw17, md17;
  coord_t             hmax, hmin;
  logic               pass;

  assign rows[0] = cfg.row_x;
  assign rows[1] = cfg.row_y;
  assign rows[2] = cfg.row_z;
  assign pt[0]   = points.point_x;
  assign pt[1]   = points.point_y;
  assign pt[2]   = points.point_z;

  // in-flight words reserve a queue slot each, so the pipe never stalls
  assign points.ready = ({1'b0, q_count} + (CW+1)'(s1_v) + (CW+1)'(s2_v))
                        < (CW+1)'(QUEUE_DEPTH);
  assign accept  = points.valid && points.ready;
  assign keep    = (dec_cnt == 8'd0);
  assign dec_eff = (cfg.decimation == 8'd0) ? 8'd1 : cfg.decimation;
  assign cnt_inc = {1'b0, dec_cnt} + 9'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dec_cnt <= 8'd0;
    end else if (accept) begin
      if (points.last_point || cnt_inc >= {1'b0, dec_eff}) begin
        dec_cnt <= 8'd0;
      end else begin
        dec_cnt <= cnt_inc[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else begin
      s1_v <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kv   <= keep && points.point_valid;
      s1_last <= points.last_point;
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          prod[r][k] <= $signed(rows[r][63-16*k -: 16]) * pt[k];
        end
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r] = 34'(prod[r][0]) + 34'(prod[r][1]) + 34'(prod[r][2])
             + $signed({{4{rows[r][15]}}, rows[r][15:0], 14'b0}) + 34'sd8192;
      coord[r] = sat16(acc[r][33:14]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v) begin
      s2_kv   <= s1_kv;
      s2_last <= s1_last;
      for (int r = 0; r < 3; r++) begin
        s2_c[r] <= coord[r];
      end
    end
  end

  always_comb begin
    y17  = 17'(s2_c[1]);
    ay   = (y17 < 0) ? -y17 : y17;
    x17  = 17'(s2_c[0]);
    hw17 = $signed({2'b00, cfg.half_width_mm});
    md17 = $signed({2'b00, cfg.max_depth_mm});
    hmax = $signed(cfg.height_window[31:16]);
    hmin = $signed(cfg.height_window[15:0]);
    pass = s2_kv && (ay <= hw17) && (x17 <= md17) && (s2_c[2] <= hmax) && (s2_c[2] >= hmin);
  end

  assign push           = s2_v && (pass || s2_last);
  assign push_item.xt   = s2_c[0];
  assign push_item.yt   = s2_c[1];
  assign push_item.zt   = s2_c[2];
  assign push_item.pass = pass;
  assign push_item.last = s2_last;

endmodule

/* hw/rtl/fnpf_queue.sv */
// ============================================================================
// fnpf_queue
// Short FIFO of classified points between front and back.
// ============================================================================
module fnpf_queue import fnpf_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  localparam int CW = $clog2(QUEUE_DEPTH + 1),
  localparam int PW = $clog2(QUEUE_DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  q_item_t       push_item,
  input  logic          pop,
  output q_item_t       head,
  output logic [CW-1:0] count
);

  q_item_t       mem [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign head = mem[rd_ptr];

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count < CW'(QUEUE_DEPTH)))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != '0))
    else $error("queue read while empty");

endmodule

/* hw/rtl/fnpf_back.sv */
// ============================================================================
// fnpf_back
// Nearest point tracking, low-pass filter and result register.
// ============================================================================
module fnpf_back import fnpf_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         cfg,
  input  logic         avail,
  input  q_item_t      head,
  output logic         pop,
  fnpf_result_if.source result
);

  coord_t             min_x, min_y, min_z;
  logic               found;
  logic               take_new, pop_last;
  coord_t             nx, ny, nz, max_depth;
  logic               fnd;
  logic [15:0]        gain;
  logic signed [15:0] bias;
  logic signed [17:0] gain_inv;
  logic signed [23:0] prev;

  logic               f1_v, f1_found, f1_adv;
  logic signed [40:0] prod_a;
  logic signed [33:0] prod_b;
  coord_t             f1_x, f1_y, f1_z;

  logic signed [42:0] facc;
  logic signed [27:0] fv;
  logic signed [23:0] vsat;
  logic signed [24:0] vr;
  logic signed [16:0] mmr;
  coord_t             mm;

  logic               out_v;
  coord_t             out_d, out_x, out_y, out_z;
  logic               out_found;

  assign gain      = cfg.filter_settings[15:0];
  assign bias      = $signed(cfg.filter_settings[31:16]);
  assign gain_inv  = 18'sd65536 - $signed({2'b00, gain});
  assign max_depth = $signed({1'b0, cfg.max_depth_mm});

  // a new cloud end waits for the previous filter value
  assign pop      = avail && (!head.last || !f1_v);
  assign pop_last = pop && head.last;
  assign take_new = head.pass && (!found || head.xt < min_x);
  assign f1_adv   = f1_v && (!out_v || result.ready);

  always_comb begin
    if (take_new) begin
      nx  = head.xt;
      ny  = head.yt;
      nz  = head.zt;
      fnd = 1'b1;
    end else if (found) begin
      nx  = min_x;
      ny  = min_y;
      nz  = min_z;
      fnd = 1'b1;
    end else begin
      nx  = max_depth;
      ny  = '0;
      nz  = '0;
      fnd = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (pop_last) begin
      found <= 1'b0;
    end else if (pop && take_new) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && take_new && !head.last) begin
      min_x <= head.xt;
      min_y <= head.yt;
      min_z <= head.zt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_v <= 1'b0;
    end else if (pop_last) begin
      f1_v <= 1'b1;
    end else if (f1_adv) begin
      f1_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_last) begin
      prod_a   <= $signed({1'b0, gain}) * prev;
      prod_b   <= gain_inv * nx;
      f1_x     <= nx;
      f1_y     <= ny;
      f1_z     <= nz;
      f1_found <= fnd;
    end
  end

  always_comb begin
    facc = 43'(prod_a) + (43'(prod_b) <<< 8) + 43'sd32768;
    fv   = 28'($signed(facc[42:16])) - (28'(bias) <<< 8);
    if (fv > 28'sd8388607) begin
      vsat = 24'sh7fffff;
    end else if (fv < -28'sd8388608) begin
      vsat = 24'sh800000;
    end else begin
      vsat = fv[23:0];
    end
    vr  = 25'(vsat) + 25'sd128;
    mmr = vr[24:8];
    if (mmr > 17'sd32767) begin
      mm = 16'sh7fff;
    end else begin
      mm = mmr[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev <= '0;
    end else if (f1_adv) begin
      prev <= vsat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (f1_adv) begin
      out_v <= 1'b1;
    end else if (result.ready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (f1_adv) begin
      out_d     <= mm;
      out_x     <= f1_x;
      out_y     <= f1_y;
      out_z     <= f1_z;
      out_found <= f1_found;
    end
  end

  assign result.valid             = out_v;
  assign result.filtered_distance = out_d;
  assign result.nearest_x         = out_x;
  assign result.nearest_y         = out_y;
  assign result.nearest_z         = out_z;
  assign result.point_found       = out_found;

  a_last_starts_filter: assert property (@(posedge clk) disable iff (rst)
    pop_last |=> (f1_v && !found))
    else $error("cloud end did not start filter or clear tracking");

  a_filter_holds: assert property (@(posedge clk) disable iff (rst)
    (f1_v && !f1_adv) |=> (f1_v && $stable(prod_a) && $stable(prod_b)))
    else $error("stalled filter stage lost its operands");

  a_prev_only_on_adv: assert property (@(posedge clk) disable iff (rst)
    !f1_adv |=> $stable(prev))
    else $error("filter state changed without a result");

endmodule

/* hw/rtl/frontal_nearest_point_filter.sv */
// ============================================================================
// frontal_nearest_point_filter
// Nearest forward point of a point cloud with low-pass filtered distance.
// ============================================================================
// Channels: points (sink) takes one sensor point per word, in mm, with a
// valid flag and a last-of-cloud flag. result (source) gives one word per
// cloud: filtered distance, nearest robot-frame point and a found flag.
// cfg (sink) writes one register per word; it is always ready and should
// only be used while no cloud is in flight.
// Throughput: one point per cycle while points.ready is high. The front is
// a two-stage transform pipe whose slots are reserved in an eight-entry
// queue; the back pops one word per cycle but holds a cloud end until the
// previous filter value has moved on to the result register.
// Result path: stages s1 and s2, the queue, f1, then the result register.
// Reset: registers take their defaults, tracking and filter state clear.
// When the receiver stalls the result register holds, the queue fills and
// points.ready drops once all queue slots are reserved.
// ============================================================================
module frontal_nearest_point_filter import fnpf_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  fnpf_point_if.sink    points,
  fnpf_result_if.source result,
  fnpf_cfg_if.sink      cfg
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cfg_t          regs;
  logic          push, pop, avail;
  q_item_t       push_item, head;
  logic [CW-1:0] q_count;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.row_x           <= ROW_X_RST;
      regs.row_y           <= ROW_Y_RST;
      regs.row_z           <= ROW_Z_RST;
      regs.half_width_mm   <= HALF_WIDTH_RST;
      regs.max_depth_mm    <= MAX_DEPTH_RST;
      regs.height_window   <= HEIGHT_WINDOW_RST;
      regs.filter_settings <= FILTER_RST;
      regs.decimation      <= DECIMATION_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_ROW_X:         regs.row_x           <= cfg.data;
        REG_ROW_Y:         regs.row_y           <= cfg.data;
        REG_ROW_Z:         regs.row_z           <= cfg.data;
        REG_HALF_WIDTH:    regs.half_width_mm   <= cfg.data[14:0];
        REG_MAX_DEPTH:     regs.max_depth_mm    <= cfg.data[14:0];
        REG_HEIGHT_WINDOW: regs.height_window   <= cfg.data[31:0];
        REG_FILTER:        regs.filter_settings <= cfg.data[31:0];
        REG_DECIMATION:    regs.decimation      <= cfg.data[7:0];
        default: begin
        end
      endcase
    end
  end

  fnpf_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (regs),
    .points    (points),
    .q_count   (q_count),
    .push      (push),
    .push_item (push_item)
  );

  fnpf_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .count     (q_count)
  );

  assign avail = (q_count != '0);

  fnpf_back u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (regs),
    .avail  (avail),
    .head   (head),
    .pop    (pop),
    .result (result)
  );

endmodule

/* bench/frontal_nearest_point_filter_test.sv */
`timescale 1ns / 100ps
// ============================================================================
// frontal_nearest_point_filter_test
// Self-checking bench for the frontal nearest point filter.
// Point clouds go in one word per point. A bit-true predictor tracks the
// decimation, the transform, the box test, the nearest point and the
// low-pass filter, and each result word is checked field by field.
// Directed clouds cover field and register extremes. Random clouds then
// run under changing register settings, random idling on both channels,
// a long receiver hold-off and drained pauses.
// ============================================================================
module frontal_nearest_point_filter_test;
  import fnpf_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLD_CYCLES    = 300;

  typedef struct {
    coord_t distance;
    coord_t x;
    coord_t y;
    coord_t z;
    logic   found;
  } report_t;

  logic clk = 1'b0;
  logic rst;

  always #5 clk = ~clk;

  fnpf_point_if  points();
  fnpf_result_if result();
  fnpf_cfg_if    cfg();

  frontal_nearest_point_filter i_dut (
    .clk    (clk),
    .rst    (rst),
    .points (points),
    .result (result),
    .cfg    (cfg)
  );

  // register copy and tracking state of the predictor
  cfg_t    cfg_shadow;
  coord_t  near_x;
  coord_t  near_y;
  coord_t  near_z;
  logic    near_found;
  int      point_index;
  int      prev_filtered;
  report_t pending_reports[$];

  int send_idle_pct;
  int recv_idle_pct;
  int hold_left;
  int idle_cycles;
  int error_count;
  int points_sent;
  int clouds_checked;
  int settings_used;

  function automatic cfg_t default_config();
    cfg_t c;
    c.row_x           = ROW_X_RST;
    c.row_y           = ROW_Y_RST;
    c.row_z           = ROW_Z_RST;
    c.half_width_mm   = HALF_WIDTH_RST;
    c.max_depth_mm    = MAX_DEPTH_RST;
    c.height_window   = HEIGHT_WINDOW_RST;
    c.filter_settings = FILTER_RST;
    c.decimation      = DECIMATION_RST;
    return c;
  endfunction

  function automatic longint clamp_range(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic int rand_between(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic coord_t transform_row(logic [63:0] row, coord_t px, coord_t py,
                                           coord_t pz);
    longint acc;
    acc = longint'($signed(row[63:48])) * px + longint'($signed(row[47:32])) * py
        + longint'($signed(row[31:16])) * pz + longint'($signed(row[15:0])) * 16384
        + 8192;
    return coord_t'(clamp_range(acc >>> 14, -32768, 32767));
  endfunction

  task automatic track_point(coord_t px, coord_t py, coord_t pz, logic pv, logic last);
    int      dec;
    logic    keep;
    coord_t  xt;
    coord_t  yt;
    coord_t  zt;
    int      ay;
    logic    pass;
    longint  g;
    longint  bias;
    longint  acc;
    longint  v;
    report_t rep;
    dec = (cfg_shadow.decimation == 0) ? 1 : int'(cfg_shadow.decimation);
    keep = (point_index == 0);
    point_index = (point_index + 1 >= dec) ? 0 : point_index + 1;
    if (keep && pv) begin
      xt = transform_row(cfg_shadow.row_x, px, py, pz);
      yt = transform_row(cfg_shadow.row_y, px, py, pz);
      zt = transform_row(cfg_shadow.row_z, px, py, pz);
      ay = (yt < 0) ? -int'(yt) : int'(yt);
      pass = ay <= int'(cfg_shadow.half_width_mm) &&
             int'(xt) <= int'(cfg_shadow.max_depth_mm) &&
             zt <= $signed(cfg_shadow.height_window[31:16]) &&
             zt >= $signed(cfg_shadow.height_window[15:0]);
      if (pass && (!near_found || xt < near_x)) begin
        near_x     = xt;
        near_y     = yt;
        near_z     = zt;
        near_found = 1'b1;
      end
    end
    if (last) begin
      if (!near_found) begin
        near_x = coord_t'(cfg_shadow.max_depth_mm);
        near_y = '0;
        near_z = '0;
      end
      g    = longint'(cfg_shadow.filter_settings[15:0]);
      bias = longint'($signed(cfg_shadow.filter_settings[31:16]));
      acc  = g * prev_filtered + (65536 - g) * (longint'(near_x) * 256) + 32768;
      v    = clamp_range((acc >>> 16) - bias * 256, -8388608, 8388607);
      prev_filtered = int'(v);
      rep.distance = coord_t'(clamp_range((v + 128) >>> 8, -32768, 32767));
      rep.x        = near_x;
      rep.y        = near_y;
      rep.z        = near_z;
      rep.found    = near_found;
      pending_reports.push_back(rep);
      near_x      = coord_t'(cfg_shadow.max_depth_mm);
      near_y      = '0;
      near_z      = '0;
      near_found  = 1'b0;
      point_index = 0;
    end
  endtask

  task automatic send_point(coord_t x, coord_t y, coord_t z, logic pv, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      points.valid <= 1'b0;
      @(posedge clk);
    end
    points.valid       <= 1'b1;
    points.point_x     <= x;
    points.point_y     <= y;
    points.point_z     <= z;
    points.point_valid <= pv;
    points.last_point  <= last;
    @(posedge clk);
    while (!points.ready) @(posedge clk);
    track_point(x, y, z, pv, last);
    points_sent++;
  endtask

  task automatic wait_for_reports();
    points.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_config(cfg_t next);
    cfg_reg_t    r = REG_ROW_X;
    logic [63:0] value;
    wait_for_reports();
    r = r.first();
    repeat (r.num()) begin
      case (r)
        REG_ROW_X:         value = next.row_x;
        REG_ROW_Y:         value = next.row_y;
        REG_ROW_Z:         value = next.row_z;
        REG_HALF_WIDTH:    value = 64'(next.half_width_mm);
        REG_MAX_DEPTH:     value = 64'(next.max_depth_mm);
        REG_HEIGHT_WINDOW: value = 64'(next.height_window);
        REG_FILTER:        value = 64'(next.filter_settings);
        REG_DECIMATION:    value = 64'(next.decimation);
        default:           value = '0;
      endcase
      cfg.valid <= 1'b1;
      cfg.index <= r;
      cfg.data  <= value;
      @(posedge clk);
      while (!cfg.ready) @(posedge clk);
      r = r.next();
    end
    cfg.valid <= 1'b0;
    cfg_shadow = next;
    settings_used++;
  endtask

  function automatic cfg_t rand_config();
    cfg_t        c;
    logic [63:0] rows[3];
    int          axis;
    for (int k = 0; k < 3; k++) begin
      if ($urandom_range(9) == 0) begin
        rows[k] = {$urandom, $urandom};
      end else begin
        axis = ($urandom_range(3) == 0) ? int'($urandom_range(2)) : k;
        rows[k] = '0;
        for (int a = 0; a < 3; a++) begin
          rows[k][63 - 16 * a -: 16] = 16'(rand_between(-1500, 1500) +
              ((a == axis) ? (($urandom_range(4) == 0) ? -16384 : 16384) : 0));
        end
        rows[k][15:0] = 16'(rand_between(-400, 400));
      end
    end
    c.row_x = rows[0];
    c.row_y = rows[1];
    c.row_z = rows[2];
    c.half_width_mm = ($urandom_range(7) == 0) ? 15'($urandom) : 15'(rand_between(100, 2000));
    c.max_depth_mm  = ($urandom_range(7) == 0) ? 15'(rand_between(500, 32767))
                                               : 15'(rand_between(500, 8000));
    if ($urandom_range(9) == 0)
      c.height_window = $urandom;
    else
      c.height_window = {16'(rand_between(500, 3000)), 16'(rand_between(-300, 400))};
    c.filter_settings = {(($urandom_range(5) == 0) ? 16'($urandom)
                                                  : 16'(rand_between(-60, 60))),
                         16'($urandom)};
    c.decimation = ($urandom_range(9) == 0) ? 8'($urandom) : 8'(rand_between(1, 4));
    return c;
  endfunction

  task automatic send_random_cloud();
    int     len;
    logic   noisy;
    coord_t x;
    coord_t y;
    coord_t z;
    logic   pv;
    len   = ($urandom_range(9) == 0) ? 1 : rand_between(2, 30);
    noisy = ($urandom_range(9) == 0);
    for (int i = 0; i < len; i++) begin
      if (noisy || $urandom_range(6) == 0) begin
        x = coord_t'($urandom);
        y = coord_t'($urandom);
        z = coord_t'($urandom);
        pv = noisy ? logic'($urandom_range(1)) : 1'b1;
      end else begin
        x = coord_t'(rand_between(-500, 6000));
        y = coord_t'(rand_between(-1500, 1500));
        z = coord_t'(rand_between(-300, 2500));
        pv = ($urandom_range(11) != 0);
      end
      send_point(x, y, z, pv, i == len - 1);
    end
  endtask

  // ---- tests ----

  task automatic test_default_registers();
    // nearest kept on a tie, border values pass, out-of-box and invalid skipped
    send_point(16'sd1000, 16'sd0, 16'sd100, 1'b1, 1'b0);
    send_point(16'sd800, 16'sd350, 16'sd5, 1'b1, 1'b0);
    send_point(16'sd800, -16'sd350, 16'sd1700, 1'b1, 1'b0);
    send_point(16'sd700, 16'sd351, 16'sd100, 1'b1, 1'b0);
    send_point(16'sd100, 16'sd0, 16'sd100, 1'b0, 1'b0);
    send_point(16'sd4000, 16'sd0, 16'sd100, 1'b1, 1'b0);
    send_point(-16'sd32768, -16'sd32768, -16'sd32768, 1'b1, 1'b0);
    send_point(16'sd32767, 16'sd32767, 16'sd32767, 1'b1, 1'b1);
    // clouds with nothing found
    send_point(16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b1);
    send_point(16'sd4001, 16'sd0, 16'sd100, 1'b1, 1'b1);
    send_point(16'sd500, 16'sd0, 16'sd4, 1'b1, 1'b1);
  endtask

  task automatic test_register_extremes();
    cfg_t c;
    // saturating transform, widest box, full gain, most negative bias
    c = default_config();
    c.row_x           = {4{16'h8000}};
    c.row_y           = {4{16'h7FFF}};
    c.row_z           = {16'h0000, 16'h0000, 16'h4000, 16'h7FFF};
    c.half_width_mm   = 15'h7FFF;
    c.max_depth_mm    = 15'h7FFF;
    c.height_window   = {16'h7FFF, 16'h8000};
    c.filter_settings = {16'h8000, 16'hFFFF};
    c.decimation      = 8'd255;
    load_config(c);
    send_point(16'sd32767, 16'sd32767, 16'sd32767, 1'b1, 1'b0);
    send_point(-16'sd32768, -16'sd32768, -16'sd32768, 1'b1, 1'b0);
    send_point(16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1);
    // empty height window, zero width, zero gain, largest bias, decimation 0
    c = default_config();
    c.half_width_mm   = 15'd0;
    c.max_depth_mm    = 15'd500;
    c.height_window   = {16'd50, 16'd100};
    c.filter_settings = {16'h7FFF, 16'h0000};
    c.decimation      = 8'd0;
    load_config(c);
    send_point(16'sd0, 16'sd0, 16'sd60, 1'b1, 1'b0);
    send_point(16'sd100, 16'sd0, 16'sd75, 1'b1, 1'b1);
    // decimation by three
    c.height_window = HEIGHT_WINDOW_RST;
    c.decimation    = 8'd3;
    load_config(c);
    send_point(16'sd400, 16'sd0, 16'sd100, 1'b1, 1'b0);
    send_point(16'sd300, 16'sd0, 16'sd100, 1'b1, 1'b0);
    send_point(16'sd200, 16'sd0, 16'sd100, 1'b1, 1'b0);
    send_point(16'sd100, 16'sd0, 16'sd100, 1'b1, 1'b0);
    send_point(16'sd450, 16'sd0, 16'sd100, 1'b1, 1'b1);
  endtask

  task automatic test_random_clouds(int n_points);
    int start;
    start = points_sent;
    while (points_sent - start < n_points) begin
      if ($urandom_range(7) == 0)
        load_config(rand_config());
      send_random_cloud();
    end
  endtask

  task automatic test_backpressure();
    load_config(default_config());
    hold_left = HOLD_CYCLES;
    repeat (40) begin
      repeat (rand_between(0, 2))
        send_point(coord_t'(rand_between(0, 3000)), coord_t'(rand_between(-400, 400)),
                   coord_t'(rand_between(0, 1800)), 1'b1, 1'b0);
      send_point(coord_t'(rand_between(0, 3000)), coord_t'(rand_between(-400, 400)),
                 coord_t'(rand_between(0, 1800)), 1'b1, 1'b1);
    end
    // sender pauses until the backlog has drained
    wait_for_reports();
    test_random_clouds(60);
  endtask

  // ---- receiver ----

  always @(posedge clk) begin
    if (hold_left > 0) begin
      result.ready <= 1'b0;
      hold_left--;
    end else begin
      result.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---- result checker ----

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    report_t want;
    if (!rst && result.valid === 1'b1 && result.ready === 1'b1) begin
      if (pending_reports.size() == 0) begin
        $error("result word with no report pending");
        error_count++;
      end else begin
        want = pending_reports.pop_front();
        check_field("filtered_distance", want.distance, result.filtered_distance);
        check_field("nearest_x", want.x, result.nearest_x);
        check_field("nearest_y", want.y, result.nearest_y);
        check_field("nearest_z", want.z, result.nearest_z);
        check_field("point_found", want.found, result.point_found);
        clouds_checked++;
      end
    end
  end

  // ---- watchdog ----

  always @(posedge clk) begin
    if (!rst && ((points.valid && points.ready) || (result.valid && result.ready) ||
                 (cfg.valid && cfg.ready)))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst                = 1'b1;
    points.valid       = 1'b0;
    points.point_x     = '0;
    points.point_y     = '0;
    points.point_z     = '0;
    points.point_valid = 1'b0;
    points.last_point  = 1'b0;
    result.ready       = 1'b0;
    cfg.valid          = 1'b0;
    cfg.index          = REG_ROW_X;
    cfg.data           = '0;
    cfg_shadow         = default_config();
    near_x             = coord_t'(MAX_DEPTH_RST);
    near_y             = '0;
    near_z             = '0;
    near_found         = 1'b0;
    point_index        = 0;
    prev_filtered      = 0;
    hold_left          = 0;
    idle_cycles        = 0;
    error_count        = 0;
    points_sent        = 0;
    clouds_checked     = 0;
    settings_used      = 1;
    send_idle_pct      = 19;
    recv_idle_pct      = 85;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_default_registers();
    test_register_extremes();
    test_random_clouds(620);
    send_idle_pct = 85;
    recv_idle_pct = 19;
    test_random_clouds(620);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_clouds(560);
    test_backpressure();
    wait_for_reports();

    $display("Covered %0d points, %0d clouds checked, %0d register settings,",
             points_sent, clouds_checked, settings_used);
    $display("with idling on both channels, a long result hold-off and drained pauses.");
    if (error_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
